// ===== design/msaa_pkg.sv =====
// Shared constants for the masked surface area accumulator.
// No dependencies; used by masked_surface_area_accumulator.
`default_nettype none

package msaa_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int COORD_BITS_DEF = 16;

  localparam int FIELD_W  = 16;   // width of each coordinate field on the bus
  localparam int IN_DW    = 56;   // in_tdata width (50 bits used)
  localparam int OUT_DW   = 56;   // out_tdata width (49 bits used)
  localparam int SUM_W    = 48;
  localparam int CFG_DW   = 16;
  localparam int FW_W     = 11;
  localparam int FH_W     = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  // configuration register indexes
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

endpackage

`default_nettype wire

// ===== design/masked_surface_area_accumulator.sv =====
// Masked surface area accumulator: row store memory, cross product, squaring
// and square root sequencer, saturating frame sum. Depends on msaa_pkg.
`default_nettype none

// Takes one organized point cloud pixel per transaction in raster order and
// sums twice the area (mm^2) of every mesh triangle whose three corners are
// on the object and valid; one result transaction follows the last pixel of
// each frame. The previous row lives in a single-port synchronous memory of
// MAX_WIDTH entries, read and written once per pixel. All triangle math runs
// on one shared sequencer: each pixel passes through a fetch, one load per
// candidate triangle, and for each contributing triangle 6 signed multiplies,
// 9 partial squares and a COORD_BITS*2+2 step square root. For the last pixel
// of a frame, the pixel's final state waits while the previous frame result is
// still not taken. A configuration write restarts the frame; the row store
// needs no clearing.
module masked_surface_area_accumulator #(
  parameter int MAX_WIDTH  = msaa_pkg::MAX_WIDTH_DEF,
  parameter int COORD_BITS = msaa_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire  [0:0]                   cfg_addr,
  input  wire  [msaa_pkg::CFG_DW-1:0]  cfg_wdata,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // on_object, point_valid, point_x[15:0], point_y[15:0], point_z[15:0]
  input  wire  [msaa_pkg::IN_DW-1:0]   in_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // doubled_area[47:0], area_saturated
  output logic [msaa_pkg::OUT_DW-1:0]  out_tdata
);

  localparam int CB  = COORD_BITS;
  localparam int PW  = 2 + 3 * CB;          // stored pixel
  localparam int AW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int DW  = CB + 1;              // corner differences
  localparam int PRW = 2 * DW;              // signed products
  localparam int MAG = 2 * CB + 1;          // cross component magnitude
  localparam int HW  = CB + 1;              // low half of a magnitude
  localparam int SW  = 4 * CB + 4;          // sum of squares
  localparam int RW  = 2 * CB + 2;          // square root
  localparam int RMW = RW + 2;              // root remainder
  localparam int RCW = $clog2(RW + 1);
  localparam int EW  = ((RW > msaa_pkg::SUM_W) ? RW : msaa_pkg::SUM_W) + 1;
  localparam int FW  = msaa_pkg::FIELD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_TLOAD, S_CR_MUL, S_CR_ADD, S_SQ_MUL, S_SQ_ADD,
    S_ROOT, S_ACC, S_DONE
  } state_t;

  state_t state_r;

  logic [msaa_pkg::FW_W-1:0]  frame_width_r;
  logic [msaa_pkg::FH_W-1:0]  frame_height_r;
  logic [AW-1:0]              col_r;
  logic [15:0]                row_r;
  logic [msaa_pkg::SUM_W-1:0] sum_r;
  logic                       sat_r;
  logic [PW-1:0]              pix_r, left_r, ul_r;
  logic                       tri_r;
  logic signed [DW-1:0]       ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic [2:0]                 k_r;
  logic signed [PRW-1:0]      prod_r, first_r;
  logic [MAG-1:0]             mag_r [3];
  logic [1:0]                 comp_r, part_r;
  logic [2*HW-1:0]            sq_prod_r;
  logic [SW-1:0]              rad_r;
  logic [RW-1:0]              root_r;
  logic [RMW-1:0]             rem_r;
  logic [RCW-1:0]             rcnt_r;
  logic                       out_valid_r;
  logic [msaa_pkg::SUM_W-1:0] out_sum_r;
  logic                       out_sat_r;

  // row store
  logic [PW-1:0] row_mem [MAX_WIDTH];
  logic [PW-1:0] mem_q;
  logic          accept;
  logic [PW-1:0] in_pix;

  assign accept = in_tvalid && in_tready;
  assign in_pix = {CB'(in_tdata[2+2*FW +: FW]), CB'(in_tdata[2+FW +: FW]),
                   CB'(in_tdata[2 +: FW]), in_tdata[1], in_tdata[0]};

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q        <= row_mem[col_r];
      row_mem[col_r] <= in_pix;
    end
  end

  // effective frame geometry
  logic [AW-1:0] wlast;
  logic [15:0]   hlast;
  logic          last_pix;

  always_comb begin
    if (frame_width_r < 11'd2) begin
      wlast = AW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      wlast = AW'(MAX_WIDTH - 1);
    end else begin
      wlast = AW'(frame_width_r - 11'd1);
    end
    hlast    = (frame_height_r < 16'd2) ? 16'd1 : frame_height_r - 16'd1;
    last_pix = (col_r == wlast) && (row_r >= hlast);
  end

  // triangle corners
  logic [PW-1:0] pa, pb, pc;
  logic          tri_ok;

  always_comb begin
    if (!tri_r) begin
      pa = ul_r;  pb = mem_q; pc = left_r;
    end else begin
      pa = mem_q; pb = left_r; pc = pix_r;
    end
    tri_ok = pa[0] && pa[1] && pb[0] && pb[1] && pc[0] && pc[1];
  end

  function automatic logic signed [DW-1:0] cdiff(input logic [CB-1:0] b,
                                                 input logic [CB-1:0] a);
    cdiff = $signed({b[CB-1], b}) - $signed({a[CB-1], a});
  endfunction

  // cross product multiplier
  logic signed [DW-1:0]  op_a, op_b;
  logic signed [PRW-1:0] diff;
  logic [MAG-1:0]        diff_mag;

  always_comb begin
    case (k_r)
      3'd0:    begin op_a = uy_r; op_b = vz_r; end
      3'd1:    begin op_a = uz_r; op_b = vy_r; end
      3'd2:    begin op_a = uz_r; op_b = vx_r; end
      3'd3:    begin op_a = ux_r; op_b = vz_r; end
      3'd4:    begin op_a = ux_r; op_b = vy_r; end
      default: begin op_a = uy_r; op_b = vx_r; end
    endcase
    diff     = first_r - prod_r;
    diff_mag = diff[PRW-1] ? MAG'(-diff) : MAG'(diff);
  end

  // squaring: m = h*2^HW + l, m^2 = h^2<<2HW + hl<<(HW+1) + l^2
  logic [HW-1:0] sq_h, sq_l, sq_a, sq_b;
  logic [SW-1:0] sq_term;

  always_comb begin
    sq_h = HW'(mag_r[comp_r][MAG-1:HW]);
    sq_l = mag_r[comp_r][HW-1:0];
    case (part_r)
      2'd0:    begin sq_a = sq_h; sq_b = sq_h; end
      2'd1:    begin sq_a = sq_h; sq_b = sq_l; end
      default: begin sq_a = sq_l; sq_b = sq_l; end
    endcase
    case (part_r)
      2'd0:    sq_term = SW'(sq_prod_r) << (2 * HW);
      2'd1:    sq_term = SW'(sq_prod_r) << (HW + 1);
      default: sq_term = SW'(sq_prod_r);
    endcase
  end

  // one restoring square root step
  logic [RMW+1:0] rem_cat, trial;
  logic           root_ge;

  always_comb begin
    rem_cat = {rem_r, rad_r[SW-1:SW-2]};
    trial   = (RMW+2)'({root_r, 2'b01});
    root_ge = rem_cat >= trial;
  end

  // saturating add
  logic [EW-1:0] total;
  assign total = EW'(sum_r) + EW'(root_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      frame_width_r  <= msaa_pkg::FRAME_WIDTH_RST;
      frame_height_r <= msaa_pkg::FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      sum_r          <= '0;
      sat_r          <= 1'b0;
      left_r         <= '0;
      ul_r           <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // a new frame result loaded in S_DONE keeps the flag set
      if (out_valid_r && out_tready && !(state_r == S_DONE && last_pix)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          msaa_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[msaa_pkg::FW_W-1:0];
          msaa_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
          default: ;
        endcase
        col_r  <= '0;
        row_r  <= '0;
        sum_r  <= '0;
        sat_r  <= 1'b0;
        left_r <= '0;
        ul_r   <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pix_r   <= in_pix;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          tri_r   <= 1'b0;
          state_r <= (col_r != '0 && row_r != '0) ? S_TLOAD : S_DONE;
        end
        S_TLOAD: begin
          ux_r <= cdiff(pb[2 +: CB], pa[2 +: CB]);
          uy_r <= cdiff(pb[2+CB +: CB], pa[2+CB +: CB]);
          uz_r <= cdiff(pb[2+2*CB +: CB], pa[2+2*CB +: CB]);
          vx_r <= cdiff(pc[2 +: CB], pa[2 +: CB]);
          vy_r <= cdiff(pc[2+CB +: CB], pa[2+CB +: CB]);
          vz_r <= cdiff(pc[2+2*CB +: CB], pa[2+2*CB +: CB]);
          k_r  <= '0;
          if (tri_ok) begin
            state_r <= S_CR_MUL;
          end else if (!tri_r) begin
            tri_r <= 1'b1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_CR_MUL: begin
          prod_r  <= op_a * op_b;
          state_r <= S_CR_ADD;
        end
        S_CR_ADD: begin
          if (!k_r[0]) begin
            first_r <= prod_r;
          end else begin
            mag_r[k_r[2:1]] <= diff_mag;
          end
          if (k_r == 3'd5) begin
            rad_r   <= '0;
            comp_r  <= '0;
            part_r  <= '0;
            state_r <= S_SQ_MUL;
          end else begin
            k_r     <= k_r + 3'd1;
            state_r <= S_CR_MUL;
          end
        end
        S_SQ_MUL: begin
          sq_prod_r <= sq_a * sq_b;
          state_r   <= S_SQ_ADD;
        end
        S_SQ_ADD: begin
          rad_r   <= rad_r + sq_term;
          state_r <= S_SQ_MUL;
          if (part_r == 2'd2) begin
            part_r <= '0;
            comp_r <= comp_r + 2'd1;
            if (comp_r == 2'd2) begin
              root_r  <= '0;
              rem_r   <= '0;
              rcnt_r  <= RCW'(RW);
              state_r <= S_ROOT;
            end
          end else begin
            part_r <= part_r + 2'd1;
          end
        end
        S_ROOT: begin
          rad_r <= rad_r << 2;
          if (root_ge) begin
            rem_r  <= RMW'(rem_cat - trial);
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= RMW'(rem_cat);
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          rcnt_r <= rcnt_r - RCW'(1);
          if (rcnt_r == RCW'(1)) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (total > EW'(msaa_pkg::SUM_MAX)) begin
            sum_r <= msaa_pkg::SUM_MAX;
            sat_r <= 1'b1;
          end else begin
            sum_r <= total[msaa_pkg::SUM_W-1:0];
          end
          if (!tri_r) begin
            tri_r   <= 1'b1;
            state_r <= S_TLOAD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!(last_pix && out_valid_r && !out_tready)) begin
            state_r <= S_IDLE;
            if (last_pix) begin
              out_valid_r <= 1'b1;
              out_sum_r   <= sum_r;
              out_sat_r   <= sat_r;
              col_r       <= '0;
              row_r       <= '0;
              sum_r       <= '0;
              sat_r       <= 1'b0;
              left_r      <= '0;
              ul_r        <= '0;
            end else begin
              ul_r   <= mem_q;
              left_r <= pix_r;
              if (col_r == wlast) begin
                col_r <= '0;
                row_r <= row_r + 16'd1;
              end else begin
                col_r <= col_r + AW'(1);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(msaa_pkg::OUT_DW - msaa_pkg::SUM_W - 1){1'b0}},
                       out_sat_r, out_sum_r};

`ifndef SYNTHESIS
  a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (sum_r == msaa_pkg::SUM_MAX))
    else $error("saturation flag set with sum below maximum");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast)
    else $error("column count beyond row end");

  a_one_pixel_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("pixel accepted while previous one in work");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("frame result raised outside pixel completion");
`endif

endmodule

`default_nettype wire
